// ----- rtl/pf25519_pkg.sv -----
// shared types and constants for the 2^255-19 field unit
package pf25519_pkg;

  localparam int unsigned NumLimbs = 8;
  localparam int unsigned LimbW = 32;
  localparam int unsigned NumWords = 4;
  localparam int unsigned WordW = 64;
  localparam int unsigned ValW = 256;
  localparam int unsigned IdxW = 3;

  typedef logic [ValW-1:0] val_t;

  typedef enum logic [1:0] {
    KIND_LOAD_X = 2'd0,
    KIND_LOAD_Y = 2'd1,
    KIND_EXEC   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_SQR = 3'd3,
    OP_INV = 3'd4,
    OP_NEG = 3'd5,
    OP_DBL = 3'd6,
    OP_TPL = 3'd7
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_START,
    ST_MUL_WAIT,
    ST_MUL_DONE,
    ST_RED1,
    ST_RED2,
    ST_RED3,
    ST_OUT
  } state_e;

  // cell control shared along the multiplier chain
  typedef struct packed {
    logic             clear;
    logic             shift;
    logic [LimbW-1:0] a_limb;
  } cell_ctl_t;

  // p = 2^255 - 19
  localparam val_t PrimeP = {1'b0, {250{1'b1}}, 5'b01101};

endpackage

// ----- rtl/pf25519_cell.sv -----
// one limb cell of the multiply-accumulate chain
module pf25519_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pf25519_pkg::cell_ctl_t       ctl_i,
  input  logic [pf25519_pkg::LimbW-1:0] b_limb_i,
  input  logic [pf25519_pkg::LimbW-1:0] acc_in_i,
  input  logic [pf25519_pkg::LimbW:0]   carry_in_i,
  output logic [pf25519_pkg::LimbW-1:0] acc_o,
  output logic [pf25519_pkg::LimbW:0]   carry_o
);
  import pf25519_pkg::*;

  logic [LimbW-1:0] acc_q, acc_d;
  logic [LimbW:0]   carry_q, carry_d;
  logic [2*LimbW:0] sum;

  // a*b + partial limb from the cell above + this cell's own held carry
  assign sum = {1'b0, 32'd0, acc_in_i} + ({1'b0, ctl_i.a_limb} * {1'b0, b_limb_i})
             + {32'd0, carry_in_i};

  always_comb begin
    acc_d   = acc_q;
    carry_d = carry_q;
    if (ctl_i.clear) begin
      acc_d   = '0;
      carry_d = '0;
    end else if (ctl_i.shift) begin
      acc_d   = sum[LimbW-1:0];
      carry_d = sum[2*LimbW:LimbW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      carry_q <= '0;
    end else begin
      acc_q   <= acc_d;
      carry_q <= carry_d;
    end
  end

  assign acc_o   = acc_q;
  assign carry_o = carry_q;
endmodule

// ----- rtl/pf25519_mul.sv -----
// 256x256 multiplier: chain of limb cells, one a limb per cycle, product given as lo and hi halves
module pf25519_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  pf25519_pkg::val_t a_i,
  input  pf25519_pkg::val_t b_i,
  output logic              done_o,
  output logic [pf25519_pkg::ValW-1:0] lo_o,
  output logic [pf25519_pkg::ValW-1:0] hi_o
);
  import pf25519_pkg::*;

  logic [IdxW:0]        cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 sh_q;
  logic [ValW-1:0]      lo_q, lo_d;
  cell_ctl_t            ctl;
  logic [LimbW-1:0]     acc [NumLimbs];
  logic [LimbW:0]       cry [NumLimbs];
  logic [ValW-1:0]      hi_w;
  logic [ValW-1:0]      cvec;

  always_comb begin
    ctl.clear  = start_i;
    ctl.shift  = busy_q;
    ctl.a_limb = a_i[cnt_q[IdxW-1:0]*LimbW +: LimbW];
  end

  // cell k holds product limb i+k and keeps its own carry for the next column
  for (genvar k = 0; k < NumLimbs; k++) begin : g_cell
    logic [LimbW-1:0] acc_in;
    if (k == NumLimbs - 1) begin : g_top
      assign acc_in = '0;
    end else begin : g_mid
      assign acc_in = acc[k+1];
    end
    pf25519_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .b_limb_i  (b_i[k*LimbW +: LimbW]),
      .acc_in_i  (acc_in),
      .carry_in_i(cry[k]),
      .acc_o     (acc[k]),
      .carry_o   (cry[k])
    );
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    lo_d   = lo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == (IdxW+1)'(NumLimbs - 1)) busy_d = 1'b0;
    end
    // cell 0 holds a finished product limb in the cycle after each step
    if (sh_q) lo_d = {acc[0], lo_q[ValW-1:LimbW]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sh_q   <= 1'b0;
      cnt_q  <= '0;
      lo_q   <= '0;
    end else begin
      busy_q <= busy_d;
      sh_q   <= busy_q;
      cnt_q  <= cnt_d;
      lo_q   <= lo_d;
    end
  end

  // high half: limbs of cells 1..7 plus the carries still held by every cell
  for (genvar k = 0; k < NumLimbs; k++) begin : g_hi
    if (k == NumLimbs - 1) begin : g_ht
      assign hi_w[k*LimbW +: LimbW] = '0;
    end else begin : g_hk
      assign hi_w[k*LimbW +: LimbW] = acc[k+1];
    end
    assign cvec[k*LimbW +: LimbW] = cry[k][LimbW-1:0];
  end

  assign done_o = !busy_q && !sh_q && cnt_q == (IdxW+1)'(NumLimbs);
  assign lo_o   = lo_q;
  assign hi_o   = hi_w + cvec;
endmodule

// ----- rtl/prime_field_25519_alu.sv -----
// Field unit mod 2^255-19. Load items are accepted only while idle. Add, sub, negate,
// double and triple go through the prep and reduction states, then 4 output words;
// multiply and square also run the eight-cell limb chain, which consumes one
// 32-bit limb of x per cycle; invert runs 506 chained squares and multiplies.
// Results appear as four words, least significant first, with a zero flag.
module prime_field_25519_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [1:0]  word_index_i,
  input  logic [63:0] operand_word_i,
  input  logic [2:0]  operation_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_word_o,
  output logic [1:0]  result_index_o,
  output logic        result_is_zero_o,
  output logic        last_word_o
);
  import pf25519_pkg::*;

  state_e       st_q, st_d;
  logic [63:0]  x_q [NumWords];
  logic [63:0]  y_q [NumWords];
  val_t         a_q, a_d, b_q, b_d, z_q, z_d, r_q, r_d, ma_q, ma_d, mb_q, mb_d;
  logic [2:0]   op_q, op_d;
  logic [7:0]   bit_q, bit_d;
  logic         mulph_q, mulph_d;
  logic [1:0]   oidx_q, oidx_d;
  logic [259:0] s_q, s_d;
  logic         acc;
  logic         mstart, mdone;
  val_t         mlo, mhi;
  val_t         xa, yb;
  logic [259:0] fold;
  logic [9:0]   top19;
  val_t         t1, t2;

  assign acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (st_q != ST_IDLE);

  always_comb begin
    xa = {x_q[3], x_q[2], x_q[1], x_q[0]};
    xa[255] = 1'b0;
    yb = {y_q[3], y_q[2], y_q[1], y_q[0]};
    yb[255] = 1'b0;
  end

  pf25519_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mstart),
    .a_i    (ma_q),
    .b_i    (mb_q),
    .done_o (mdone),
    .lo_o   (mlo),
    .hi_o   (mhi)
  );

  // hi * 38 folded onto lo (hi < 2^254)
  assign fold = {4'b0, mlo} + {4'b0, mhi} * 260'd38;

  // bits from 255 up are worth 19 each
  assign top19 = {1'b0, s_q[259:255], 4'b0} + {4'b0, s_q[259:255], 1'b0}
               + {5'b0, s_q[259:255]};

  always_comb begin
    t1 = {1'b0, s_q[254:0]} + {246'd0, top19};
    t2 = t1 + 256'd19;
  end

  always_comb begin
    st_d = st_q; a_d = a_q; b_d = b_q; z_d = z_q; r_d = r_q; ma_d = ma_q; mb_d = mb_q;
    op_d = op_q; bit_d = bit_q; mulph_d = mulph_q; oidx_d = oidx_q; s_d = s_q;
    mstart = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (acc && kind_i == KIND_EXEC) begin
          op_d = operation_i;
          a_d = xa; b_d = yb;
          st_d = ST_PREP;
        end
      end
      ST_PREP: begin
        unique case (op_e'(op_q))
          OP_ADD: begin s_d = {4'b0, a_q} + {4'b0, b_q}; st_d = ST_RED1; end
          OP_SUB: begin s_d = {4'b0, a_q} + {4'b0, (PrimeP << 1) - b_q}; st_d = ST_RED1; end
          OP_NEG: begin s_d = {4'b0, (PrimeP << 1) - a_q}; st_d = ST_RED1; end
          OP_DBL: begin s_d = {4'b0, a_q} + {4'b0, a_q}; st_d = ST_RED1; end
          OP_TPL: begin s_d = {4'b0, a_q} + {4'b0, a_q} + {4'b0, a_q}; st_d = ST_RED1; end
          OP_MUL: begin ma_d = a_q; mb_d = b_q; st_d = ST_MUL_START; end
          OP_SQR: begin ma_d = a_q; mb_d = a_q; st_d = ST_MUL_START; end
          default: begin
            z_d = a_q; ma_d = a_q; mb_d = a_q; bit_d = 8'd253; mulph_d = 1'b0;
            st_d = ST_MUL_START;
          end
        endcase
      end
      ST_MUL_START: begin mstart = 1'b1; st_d = ST_MUL_WAIT; end
      ST_MUL_WAIT: if (mdone) st_d = ST_MUL_DONE;
      ST_MUL_DONE: begin s_d = fold; st_d = ST_RED1; end
      ST_RED1: begin s_d = {4'b0, t1}; st_d = ST_RED2; end
      ST_RED2: begin s_d = {4'b0, t1}; st_d = ST_RED3; end
      ST_RED3: begin
        r_d = t2[255] ? {1'b0, t2[254:0]} : s_q[255:0];
        if (op_e'(op_q) == OP_INV) begin
          z_d = t2[255] ? {1'b0, t2[254:0]} : s_q[255:0];
          if (!mulph_q && bit_q != 8'd2 && bit_q != 8'd4) begin
            mulph_d = 1'b1; ma_d = z_d; mb_d = a_q; st_d = ST_MUL_START;
          end else if (bit_q == 8'd0) begin
            st_d = ST_OUT; oidx_d = '0;
          end else begin
            mulph_d = 1'b0; bit_d = bit_q - 1'b1; ma_d = z_d; mb_d = z_d;
            st_d = ST_MUL_START;
          end
        end else begin
          st_d = ST_OUT; oidx_d = '0;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          oidx_d = oidx_q + 1'b1;
          if (oidx_q == 2'd3) st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      oidx_q <= '0;
      mulph_q <= 1'b0;
      bit_q <= '0;
      op_q <= '0;
      for (int i = 0; i < NumWords; i++) begin
        x_q[i] <= '0;
        y_q[i] <= '0;
      end
    end else begin
      st_q <= st_d;
      oidx_q <= oidx_d;
      mulph_q <= mulph_d;
      bit_q <= bit_d;
      op_q <= op_d;
      if (acc && kind_i == KIND_LOAD_X) x_q[word_index_i] <= operand_word_i;
      if (acc && kind_i == KIND_LOAD_Y) y_q[word_index_i] <= operand_word_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; z_q <= z_d; r_q <= r_d;
    ma_q <= ma_d; mb_q <= mb_d; s_q <= s_d;
  end

  assign out_valid_o = (st_q == ST_OUT);
  assign result_word_o = r_q[oidx_q*WordW +: WordW];
  assign result_index_o = oidx_q;
  assign result_is_zero_o = (r_q == '0);
  assign last_word_o = (oidx_q == 2'd3);
endmodule
